/* src/rts_pkg.sv */
// Shared types, constants and limits for the rarity score sketch.
`default_nettype none
package rts_pkg;

  localparam int MAX_EST   = 16;
  localparam int MAX_SLOTS = 32;
  localparam int BIN_DEPTH = 4096;
  localparam int MAX_FEAT  = 1024;

  localparam int EST_W   = $clog2(MAX_EST);
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int BIN_W   = $clog2(BIN_DEPTH);
  localparam int FEAT_W  = $clog2(MAX_FEAT);
  localparam int CNT_W   = 21;
  localparam int NUM_W   = 20;
  localparam int SCORE_W = 25;
  localparam int LN_W    = 20;
  localparam int ACC_W   = 27;

  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
  localparam logic [SCORE_W-1:0] SCORE_CAP = '1;

  typedef enum logic [1:0] {
    OP_TABLE = 2'd0,
    OP_FIT   = 2'd1,
    OP_SCORE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_NE = 2'd0,
    REG_NS = 2'd1,
    REG_NB = 2'd2,
    REG_NF = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_TABLE = 3'd0,
    CMD_FEAT  = 3'd1,
    CMD_FIT   = 3'd2,
    CMD_SCORE = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  // One queued command from the front end
  typedef struct packed {
    cmd_t                    cmd;
    logic [EST_W-1:0]        est;
    logic [SLOT_W-1:0]       slot;
    logic [FEAT_W-1:0]       tfeat;
    logic signed [31:0]      thr;
    logic [31:0]             wt;
    logic signed [31:0]      fval;
    logic [FEAT_W-1:0]       pos;
  } qent_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [4:0]  ne;
    logic [5:0]  ns;
    logic [12:0] nb;
    logic [10:0] nf;
  } cfg_t;

  // Table entry
  typedef struct packed {
    logic [FEAT_W-1:0]  feat;
    logic signed [31:0] thr;
    logic [31:0]        wt;
  } tab_t;

endpackage
`default_nettype wire

/* src/random_threshold_sketch_rarity_score_top.sv */
// Top level: configuration registers, front end, command queue and back end.
// The back end takes table writes and non-final features without leaving idle.
// A completed sample is hashed per estimator over its slots to a bin; a fit counts
// it there, a score first logs the sample count, then adds one log per non-empty bin.
// Reset and a clear command sweep all 65536 bin counts; busy is high meanwhile.
// The receiver cannot stall: each result shows for one cycle.
`default_nettype none
module random_threshold_sketch_rarity_score_top import rts_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_op,
  input  wire logic [EST_W-1:0]   in_est_index,
  input  wire logic [SLOT_W-1:0]  in_slot_index,
  input  wire logic [FEAT_W-1:0]  in_table_feature,
  input  wire logic signed [31:0] in_table_threshold,
  input  wire logic [31:0]        in_table_weight,
  input  wire logic signed [31:0] in_feature_value,
  output logic                    out_strobe,
  output logic                    out_kind,
  output logic [NUM_W-1:0]        out_sample_number,
  output logic [SCORE_W-1:0]      out_rarity_score,
  output logic                    out_empty_bin,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_wdata
);

  logic [4:0]  ne_r;
  logic [5:0]  ns_r;
  logic [12:0] nb_r;
  logic [10:0] nf_r;
  cfg_t        cfg;
  logic        accept, push, pop, q_empty, q_full, back_busy;
  qent_t       ent, head;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= 5'd16;
      ns_r <= 6'd32;
      nb_r <= 13'd4096;
      nf_r <= 11'd1024;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NE: ne_r <= cfg_wdata[4:0];
        REG_NS: ns_r <= cfg_wdata[5:0];
        REG_NB: nb_r <= cfg_wdata;
        REG_NF: nf_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported ranges
  always_comb begin
    cfg.ne = (ne_r == '0) ? 5'd1 : (ne_r > 5'(MAX_EST)) ? 5'(MAX_EST) : ne_r;
    cfg.ns = (ns_r == '0) ? 6'd1 : (ns_r > 6'(MAX_SLOTS)) ? 6'(MAX_SLOTS) : ns_r;
    cfg.nb = (nb_r == '0) ? 13'd1 : (nb_r > 13'(BIN_DEPTH)) ? 13'(BIN_DEPTH) : nb_r;
    cfg.nf = (nf_r == '0) ? 11'd1 : (nf_r > 11'(MAX_FEAT)) ? 11'(MAX_FEAT) : nf_r;
  end

  assign busy   = q_full || back_busy;
  assign accept = start && !busy;

  rts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .op              (in_op),
    .est_index       (in_est_index),
    .slot_index      (in_slot_index),
    .table_feature   (in_table_feature),
    .table_threshold (in_table_threshold),
    .table_weight    (in_table_weight),
    .feature_value   (in_feature_value),
    .nf              (cfg.nf),
    .push            (push),
    .ent             (ent)
  );

  rts_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (ent),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  rts_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .head              (head),
    .q_empty           (q_empty),
    .pop               (pop),
    .busy              (back_busy),
    .out_strobe        (out_strobe),
    .out_kind          (out_kind),
    .out_sample_number (out_sample_number),
    .out_rarity_score  (out_rarity_score),
    .out_empty_bin     (out_empty_bin)
  );

endmodule
`default_nettype wire

/* src/rts_front.sv */
// Front end: accepts items, tracks the feature position and classifies each item.
`default_nettype none
module rts_front import rts_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [1:0]         op,
  input  wire logic [EST_W-1:0]   est_index,
  input  wire logic [SLOT_W-1:0]  slot_index,
  input  wire logic [FEAT_W-1:0]  table_feature,
  input  wire logic signed [31:0] table_threshold,
  input  wire logic [31:0]        table_weight,
  input  wire logic signed [31:0] feature_value,
  input  wire logic [10:0]        nf,
  output logic                    push,
  output qent_t                   ent
);

  logic [FEAT_W-1:0] pos_r, pos_nxt;
  logic              last;

  // Sample completes when this feature brings the count to nf or more
  assign last = ({1'b0, pos_r} + 11'd1) >= nf;
  assign push = accept;

  always_comb begin
    ent.est   = est_index;
    ent.slot  = slot_index;
    ent.tfeat = table_feature;
    ent.thr   = table_threshold;
    ent.wt    = table_weight;
    ent.fval  = feature_value;
    ent.pos   = pos_r;
    pos_nxt   = pos_r;
    unique case (op_t'(op))
      OP_TABLE: ent.cmd = CMD_TABLE;
      OP_CLEAR: begin
        ent.cmd = CMD_CLEAR;
        pos_nxt = '0;
      end
      OP_FIT, OP_SCORE: begin
        if (last) begin
          ent.cmd = (op_t'(op) == OP_FIT) ? CMD_FIT : CMD_SCORE;
          pos_nxt = '0;
        end else begin
          ent.cmd = CMD_FEAT;
          pos_nxt = pos_r + FEAT_W'(1);
        end
      end
      default: ent.cmd = CMD_TABLE;
    endcase
  end

  // Advance the position on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/rts_fifo.sv */
// Two-entry command queue between front and back end.
`default_nettype none
module rts_fifo import rts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire qent_t din,
  input  wire logic  pop,
  output qent_t      dout,
  output logic       empty,
  output logic       full
);

  qent_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign dout  = mem_r[rp_r];

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* src/rts_mod.sv */
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module rts_mod import rts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       dividend,
  input  wire logic [12:0]       divisor,
  output logic                   done,
  output logic [BIN_W-1:0]       rem
);

  logic              run_r;
  logic [4:0]        cnt_r;
  logic [31:0]       q_r;
  logic [BIN_W-1:0]  rem_r;
  logic [12:0]       d_r;
  logic [12:0]       shf, sub;

  assign shf = {rem_r, q_r[31]};
  assign sub = (shf >= d_r) ? (shf - d_r) : shf;
  assign rem = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 5'd31) begin
        run_r <= 1'b0;
        done  <= 1'b1;
      end
    end
  end

  // Shift in one bit and subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      q_r   <= {q_r[30:0], 1'b0};
      rem_r <= sub[BIN_W-1:0];
      cnt_r <= cnt_r + 5'd1;
    end
  end

endmodule
`default_nettype wire

/* src/rts_ln.sv */
// Natural logarithm in Q4.16: normalise, sixteen squarings, scale by ln 2.
`default_nettype none
module rts_ln import rts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CNT_W-1:0]  x,
  output logic                   done,
  output logic [LN_W-1:0]        res
);

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_NORM = 6'b000010,
    L_SQ   = 6'b000100,
    L_FIX  = 6'b001000,
    L_MUL  = 6'b010000,
    L_RND  = 6'b100000
  } lst_t;

  lst_t         st_r;
  logic [30:0]  y_r;
  logic [4:0]   e_r;
  logic [3:0]   i_r;
  logic [15:0]  frac_r;
  logic [61:0]  p_r;
  logic [52:0]  m_r;
  logic [31:0]  y2;
  logic [52:0]  m_rnd;

  assign y2    = p_r[61:30];
  assign m_rnd = m_r + 53'h0_8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        L_IDLE: if (start) st_r <= L_NORM;
        L_NORM: if (y_r[30]) st_r <= L_SQ;
        L_SQ:   st_r <= L_FIX;
        L_FIX:  st_r <= (i_r == 4'd0) ? L_MUL : L_SQ;
        L_MUL:  st_r <= L_RND;
        L_RND: begin
          st_r <= L_IDLE;
          done <= 1'b1;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  // Datapath: one load, shift, square, fix-up, multiply or rounding per cycle
  always_ff @(posedge clk) begin
    unique case (st_r)
      L_IDLE: begin
        y_r    <= {x, 10'b0};
        e_r    <= 5'd20;
        i_r    <= 4'd15;
        frac_r <= '0;
      end
      L_NORM: begin
        if (!y_r[30]) begin
          y_r <= {y_r[29:0], 1'b0};
          e_r <= e_r - 5'd1;
        end
      end
      L_SQ: p_r <= y_r * y_r;
      L_FIX: begin
        frac_r[i_r] <= y2[31];
        y_r         <= y2[31] ? y2[31:1] : y2[30:0];
        i_r         <= i_r - 4'd1;
      end
      L_MUL: m_r <= {e_r, frac_r} * LN2_Q32;
      L_RND: res <= m_rnd[32+LN_W-1:32];
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/rts_back.sv */
// Back end: table and buffer writes, per-sample hashing, bin counts and scoring.
`default_nettype none
module rts_back import rts_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire qent_t               head,
  input  wire logic                q_empty,
  output logic                     pop,
  output logic                     busy,
  output logic                     out_strobe,
  output logic                     out_kind,
  output logic [NUM_W-1:0]         out_sample_number,
  output logic [SCORE_W-1:0]       out_rarity_score,
  output logic                     out_empty_bin
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_LNF   = 12'b000000000100,
    S_LNFW  = 12'b000000001000,
    S_TRD   = 12'b000000010000,
    S_FRD   = 12'b000000100000,
    S_ACC   = 12'b000001000000,
    S_MOD   = 12'b000010000000,
    S_MODW  = 12'b000100000000,
    S_CRA   = 12'b001000000000,
    S_CRD   = 12'b010000000000,
    S_LNCW  = 12'b100000000000
  } st_t;

  localparam int CADR_W = EST_W + BIN_W;

  st_t                     state_r;
  logic [EST_W-1:0]        est_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [31:0]             sum_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [LN_W-1:0]         lnf_r;
  logic                    empty_r, score_r;
  logic [CNT_W-1:0]        fitted_r;
  logic [NUM_W-1:0]        scored_r;
  logic [CADR_W-1:0]       clr_r;

  tab_t                    tab_mem [MAX_EST*MAX_SLOTS];
  logic [31:0]             buf_mem [MAX_FEAT];
  logic [CNT_W-1:0]        cnt_mem [MAX_EST*BIN_DEPTH];
  tab_t                    tab_q;
  logic [31:0]             buf_q;
  logic [CNT_W-1:0]        cnt_q;

  logic                    mod_done, ln_start, ln_done;
  logic [BIN_W-1:0]        mod_rem;
  logic [LN_W-1:0]         ln_res;
  logic                    last_est, last_slot, hit, full;
  logic signed [31:0]      fv;
  logic                    cnt_we;
  logic [CADR_W-1:0]       cnt_wa;
  logic [CNT_W-1:0]        cnt_wd;
  logic [SCORE_W-1:0]      score;
  logic [ACC_W:0]          dbl;
  logic signed [ACC_W-1:0] diff;
  logic signed [ACC_W-1:0] acc_fin;
  logic                    done_smp;

  assign busy      = (state_r != S_IDLE);
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign full      = fitted_r[NUM_W];
  assign last_est  = ({1'b0, est_r} == (cfg.ne - 5'd1));
  assign last_slot = ({1'b0, slot_r} == (cfg.ns - 6'd1));
  assign fv        = ({1'b0, tab_q.feat} < cfg.nf) ? $signed(buf_q) : 32'sd0;
  assign hit       = fv > tab_q.thr;
  assign ln_start  = (state_r == S_LNF) ||
                     ((state_r == S_CRD) && score_r && (cnt_q != '0));
  assign diff      = $signed({{(ACC_W-LN_W){1'b0}}, lnf_r}) -
                     $signed({{(ACC_W-LN_W){1'b0}}, ln_res});
  // Fold in the last estimator's term while its log completes
  assign acc_fin   = (state_r == S_LNCW) ? (acc_r + diff) : acc_r;
  assign dbl       = {acc_fin, 1'b0};

  // Leaving the last estimator finishes the sample
  assign done_smp = ((state_r == S_CRD && !(score_r && cnt_q != '0)) ||
                     (state_r == S_LNCW && ln_done)) && last_est;

  // Count memory write port: clearing sweep or fit increment
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = {est_r, mod_rem};
    cnt_wd = cnt_q + CNT_W'(1);
    if (state_r == S_CLEAR) begin
      cnt_we = 1'b1;
      cnt_wa = clr_r;
      cnt_wd = '0;
    end else if (state_r == S_CRD && !score_r) begin
      cnt_we = 1'b1;
    end
  end

  // Saturate the doubled sum; a non-positive sum gives zero and an empty bin the cap
  always_comb begin
    if (empty_r)                                 score = SCORE_CAP;
    else if (acc_fin <= 0)                       score = '0;
    else if (dbl > {{(ACC_W-SCORE_W+1){1'b0}}, SCORE_CAP}) score = SCORE_CAP;
    else                                         score = dbl[SCORE_W-1:0];
  end

  // Memories
  always_ff @(posedge clk) begin
    if (pop && head.cmd == CMD_TABLE) begin
      tab_mem[{head.est, head.slot}] <= '{feat: head.tfeat, thr: head.thr, wt: head.wt};
    end
    tab_q <= tab_mem[{est_r, slot_r}];
  end

  always_ff @(posedge clk) begin
    if (pop && (head.cmd == CMD_FEAT || head.cmd == CMD_FIT || head.cmd == CMD_SCORE)) begin
      buf_mem[head.pos] <= head.fval;
    end
    buf_q <= buf_mem[tab_q.feat];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[{est_r, mod_rem}];
  end

  rts_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_MOD),
    .dividend (sum_r),
    .divisor  (cfg.nb),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  rts_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_start),
    .x     ((state_r == S_LNF) ? fitted_r : cnt_q),
    .done  (ln_done),
    .res   (ln_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      fitted_r   <= '0;
      scored_r   <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CADR_W'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          est_r   <= '0;
          slot_r  <= '0;
          sum_r   <= '0;
          acc_r   <= '0;
          empty_r <= 1'b0;
          if (pop) begin
            priority case (head.cmd)
              CMD_CLEAR: begin
                state_r  <= S_CLEAR;
                clr_r    <= '0;
                fitted_r <= '0;
                scored_r <= '0;
              end
              CMD_FIT: begin
                score_r <= 1'b0;
                if (full) begin
                  out_strobe        <= 1'b1;
                  out_kind          <= 1'b0;
                  out_sample_number <= '1;
                  out_rarity_score  <= '0;
                  out_empty_bin     <= 1'b0;
                end else begin
                  state_r <= S_TRD;
                end
              end
              CMD_SCORE: begin
                score_r <= 1'b1;
                if (fitted_r == '0) begin
                  out_strobe        <= 1'b1;
                  out_kind          <= 1'b1;
                  out_sample_number <= scored_r;
                  out_rarity_score  <= SCORE_CAP;
                  out_empty_bin     <= 1'b1;
                  scored_r          <= scored_r + NUM_W'(1);
                end else begin
                  state_r <= S_LNF;
                end
              end
              default: ;
            endcase
          end
        end
        S_LNF:  state_r <= S_LNFW;
        S_LNFW: begin
          if (ln_done) begin
            lnf_r   <= ln_res;
            state_r <= S_TRD;
          end
        end
        S_TRD: state_r <= S_FRD;
        S_FRD: state_r <= S_ACC;
        S_ACC: begin
          if (hit) sum_r <= sum_r + tab_q.wt;
          if (last_slot) begin
            state_r <= S_MOD;
          end else begin
            slot_r  <= slot_r + SLOT_W'(1);
            state_r <= S_TRD;
          end
        end
        S_MOD:  state_r <= S_MODW;
        S_MODW: if (mod_done) state_r <= S_CRA;
        S_CRA:  state_r <= S_CRD;
        S_CRD: begin
          if (score_r && cnt_q != '0) begin
            state_r <= S_LNCW;
          end else begin
            if (score_r) empty_r <= 1'b1;
            state_r <= last_est ? S_IDLE : S_TRD;
            est_r   <= est_r + EST_W'(1);
            slot_r  <= '0;
            sum_r   <= '0;
          end
        end
        S_LNCW: begin
          if (ln_done) begin
            acc_r   <= acc_r + diff;
            state_r <= last_est ? S_IDLE : S_TRD;
            est_r   <= est_r + EST_W'(1);
            slot_r  <= '0;
            sum_r   <= '0;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Report a finished sample and advance its pass counter
      if (done_smp) begin
        out_strobe <= 1'b1;
        out_kind   <= score_r;
        if (score_r) begin
          out_sample_number <= scored_r;
          out_empty_bin     <= empty_r || (state_r == S_CRD);
          out_rarity_score  <= (empty_r || state_r == S_CRD) ? SCORE_CAP : score;
          scored_r          <= scored_r + NUM_W'(1);
        end else begin
          out_sample_number <= fitted_r[NUM_W-1:0];
          out_empty_bin     <= 1'b0;
          out_rarity_score  <= '0;
          fitted_r          <= fitted_r + CNT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/rts_checker.sv */
// Port-level checker for the rarity score block, bound to the top level.
`default_nettype none
module rts_checker import rts_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic               out_kind,
  input wire logic [SCORE_W-1:0] out_rarity_score,
  input wire logic               out_empty_bin
);

  // Reset starts the count-clearing sweep
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // Reset silences the result strobe
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // A fit result carries no score
  a_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_kind) |-> (out_rarity_score == '0 && !out_empty_bin))
    else $error("fit result with score or flag");

  // An empty bin saturates the score
  a_empty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_empty_bin) |-> (out_rarity_score == SCORE_CAP))
    else $error("empty bin without saturated score");

endmodule

bind random_threshold_sketch_rarity_score_top rts_checker u_rts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_kind         (out_kind),
  .out_rarity_score (out_rarity_score),
  .out_empty_bin    (out_empty_bin)
);
`default_nettype wire
